FILE: src/top_k_sum_with_penalty_unit_defines.svh
`ifndef TOP_K_SUM_WITH_PENALTY_UNIT_DEFINES_SVH
`define TOP_K_SUM_WITH_PENALTY_UNIT_DEFINES_SVH

// checked on clk_i, off while rst_ni is low
`define TKSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on clk_i, also during reset
`define TKSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/tksp_pkg.sv
package tksp_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;

  localparam int VAL_W  = 32;
  localparam int HVAL_W = 31;
  localparam int SUM_W  = 42;
  localparam int BEST_W = 62;
  localparam int IDX_W  = 31;
  localparam int CAP_W  = 11;
  localparam int PEN_W  = 31;
  localparam int CFG_W  = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY  = 1'b1;

  typedef struct packed {
    logic             start;
    logic             clear;
    logic [VAL_W-1:0] value;
  } heap_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } heap_stat_t;

endpackage

FILE: src/tksp_ram.sv
module tksp_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: src/tksp_heap.sv
module tksp_heap #(
  parameter int HEAP_DEPTH = tksp_pkg::HEAP_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tksp_pkg::heap_req_t        req_i,
  input  logic [tksp_pkg::CAP_W-1:0] cap_i,
  output tksp_pkg::heap_stat_t       stat_o
);

  localparam int AW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W = (CNT_W > tksp_pkg::CAP_W) ? CNT_W : tksp_pkg::CAP_W;
  localparam int CH_W  = (CNT_W > AW + 2) ? CNT_W : AW + 2;
  localparam int HW    = tksp_pkg::HVAL_W;
  localparam int SW    = tksp_pkg::SUM_W;

  localparam logic [2:0] H_IDLE   = 3'd0;
  localparam logic [2:0] H_UP_RD  = 3'd1;
  localparam logic [2:0] H_UP_CMP = 3'd2;
  localparam logic [2:0] H_DN_RD  = 3'd3;
  localparam logic [2:0] H_DN_CMP = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    c_q, c_d;
  logic             rv_q, rv_d;
  logic [HW-1:0]    v_q, v_d;
  logic [HW-1:0]    root_q;
  logic             done_q, done_d;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [HW-1:0] wdata, rdata_a, rdata_b;

  logic          positive;
  logic [HW-1:0] hv;
  logic          room;
  logic [CH_W-1:0] c1, c2, cnt_ext;
  logic [AW-1:0] par;
  logic          right_lt;
  logic [HW-1:0] min_v;

  tksp_ram #(
    .WIDTH(HW),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign hv       = req_i.value[HW-1:0];
  assign positive = !req_i.value[tksp_pkg::VAL_W-1] && (req_i.value != '0);
  assign room     = (CMP_W'(count_q) < CMP_W'(cap_i)) && (CMP_W'(count_q) < CMP_W'(HEAP_DEPTH));
  assign c1       = CH_W'({pos_q, 1'b1});
  assign c2       = c1 + CH_W'(1);
  assign cnt_ext  = CH_W'(count_q);
  assign par      = (pos_q - AW'(1)) >> 1;
  assign right_lt = rv_q && (rdata_b < rdata_a);
  assign min_v    = right_lt ? rdata_b : rdata_a;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sum_d   = sum_q;
    pos_d   = pos_q;
    c_d     = c_q;
    rv_d    = rv_q;
    v_d     = v_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = v_q;
    raddr_a = '0;
    raddr_b = '0;
    unique case (state_q)
      H_IDLE: begin
        if (req_i.clear) begin
          count_d = '0;
          sum_d   = '0;
        end else if (req_i.start) begin
          if (room) begin
            if (positive) begin
              v_d     = hv;
              pos_d   = count_q[AW-1:0];
              count_d = count_q + CNT_W'(1);
              sum_d   = sum_q + SW'(hv);
              state_d = H_UP_RD;
            end else begin
              done_d = 1'b1;
            end
          end else if ((count_q != '0) && positive && (hv > root_q)) begin
            v_d     = hv;
            pos_d   = '0;
            sum_d   = sum_q - SW'(root_q) + SW'(hv);
            state_d = H_DN_RD;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      H_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          raddr_a = par;
          c_d     = par;
          state_d = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (rdata_a <= v_q) begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          wdata   = rdata_a;
          pos_d   = c_q;
          state_d = H_UP_RD;
        end
      end
      H_DN_RD: begin
        if (c1 >= cnt_ext) begin
          we      = 1'b1;
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          raddr_a = c1[AW-1:0];
          raddr_b = c2[AW-1:0];
          c_d     = c1[AW-1:0];
          rv_d    = c2 < cnt_ext;
          state_d = H_DN_CMP;
        end
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (v_q <= min_v) begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          wdata   = min_v;
          pos_d   = right_lt ? c_q + AW'(1) : c_q;
          state_d = H_DN_RD;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    c_q   <= c_d;
    rv_q  <= rv_d;
    v_q   <= v_d;
    if (we && (waddr == '0)) begin
      root_q <= wdata;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.sum  = sum_q;

endmodule

FILE: src/top_k_sum_with_penalty_unit.sv
// flow: an accepted item passes the heap update (a sift over the heap ram), the penalty
// multiply and the score step, then the result is registered at the output
// one item in flight: no new input is taken until the result of the last item is loaded,
// and a stalled result holds the next item in the score step
// reset: asynchronous, clears fill count, sum, index, best score and handshakes;
// heap ram contents are not cleared
module top_k_sum_with_penalty_unit #(
  parameter int HEAP_DEPTH = tksp_pkg::HEAP_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,  // item_value (signed)
  input  logic                           s_axis_tlast_i,  // last_item
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [103:0]                   m_axis_tdata_o,  // heap_sum[41:0], best_score[103:42]
  output logic                           m_axis_tlast_o,  // final_result
  input  logic                           cfg_we_i,
  input  logic [tksp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tksp_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int BW = tksp_pkg::BEST_W;
  localparam int IW = tksp_pkg::IDX_W;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_HEAP  = 2'd1;
  localparam logic [1:0] T_MUL   = 2'd2;
  localparam logic [1:0] T_SCORE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [tksp_pkg::CAP_W-1:0]   cap_q;
  logic [tksp_pkg::PEN_W-1:0]   pen_q;
  logic [IW-1:0]                idx_q;
  logic [BW-1:0]                best_q;
  logic [BW-1:0]                prod_q;
  logic                         last_q;
  logic                         out_valid_q;
  logic [tksp_pkg::SUM_W-1:0]   out_sum_q;
  logic [BW-1:0]                out_best_q;
  logic                         out_last_q;

  tksp_pkg::heap_req_t  heap_req;
  tksp_pkg::heap_stat_t heap_stat;

  logic          accept;
  logic          load;
  logic [BW-1:0] sum_ext, score, best_d;

  tksp_heap #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_heap (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (heap_req),
    .cap_i (cap_q),
    .stat_o(heap_stat)
  );

  assign s_axis_tready_o = (state_q == T_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load            = (state_q == T_SCORE) && (!out_valid_q || m_axis_tready_i);

  assign heap_req.start = accept;
  assign heap_req.clear = load && last_q;
  assign heap_req.value = s_axis_tdata_i;

  assign sum_ext = BW'(heap_stat.sum);
  assign score   = sum_ext - prod_q;
  assign best_d  = ((sum_ext > prod_q) && (score > best_q)) ? score : best_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (accept) state_d = T_HEAP;
      T_HEAP:  if (heap_stat.done) state_d = T_MUL;
      T_MUL:   state_d = T_SCORE;
      T_SCORE: if (load) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cap_q       <= tksp_pkg::CAP_RESET;
      pen_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tksp_pkg::CFG_CAPACITY: cap_q <= cfg_data_i[tksp_pkg::CAP_W-1:0];
          tksp_pkg::CFG_PENALTY:  pen_q <= cfg_data_i[tksp_pkg::PEN_W-1:0];
          default: ;
        endcase
      end
      if (accept && (idx_q != '1)) begin
        idx_q <= idx_q + IW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          idx_q  <= '0;
          best_q <= '0;
        end else begin
          best_q <= best_d;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= BW'(idx_q) * BW'(pen_q);
    if (accept) begin
      last_q <= s_axis_tlast_i;
    end
    if (load) begin
      out_sum_q  <= heap_stat.sum;
      out_best_q <= best_d;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_best_q, out_sum_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: src/tksp_checker.sv
`include "top_k_sum_with_penalty_unit_defines.svh"

module tksp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [103:0] m_axis_tdata_o,
  input logic         m_axis_tlast_o
);

  logic         out_stall;
  logic         in_xfer;
  logic         busy;
  logic [104:0] out_word;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign busy      = !s_axis_tready_o;
  assign out_word  = {m_axis_tlast_o, m_axis_tdata_o};

  // result held until its transfer
  `TKSP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o, "result dropped")

  `TKSP_ASSERT(a_out_stable, out_stall |=> $stable(out_word), "stalled result changed")

  // one item in flight: no input while the item passes the heap, multiply and score steps
  `TKSP_ASSERT(a_busy_after_in, in_xfer |=> busy ##1 busy ##1 busy, "input taken while busy")

  `TKSP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

endmodule

bind top_k_sum_with_penalty_unit tksp_checker u_checker (.*);
